FILE: rtl/ffba_pkg.sv
// ffba_pkg: types, constants and codes of the first-fit block allocator
// used by ffba_table and first_fit_block_allocator; no dependencies
package ffba_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int OFFSET_BITS = 20;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int SIZE_W      = 21;
	localparam int OFS_W       = 20;
	localparam int THR_W       = 11;

	localparam logic [SIZE_W-1:0] POOL_LIM   = SIZE_W'(1) << OFFSET_BITS;
	localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(65536);
	localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(32);

	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_INIT  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFIT  = 2'd1,
		ST_BADOFS = 2'd2
	} status_t;

	localparam logic [1:0] REG_POOL = 2'd0;
	localparam logic [1:0] REG_THR  = 2'd1;

	typedef enum logic [3:0] {
		S_BOOT, S_IDLE, S_SC_RD, S_SC_CHK, S_SU_RD, S_SU_WR, S_SP_LO, S_SP_HI,
		S_R_RD, S_R_CHK, S_L_RD, S_L_CHK, S_D_RD, S_D_WR, S_RESP
	} state_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic              free;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           wdata;
	} tbl_req_t;

endpackage

FILE: rtl/ffba_table.sv
// ffba_table: single-port block table, one read or one write a cycle
// registered read data; depends on ffba_pkg
module ffba_table import ffba_pkg::*; (
	input  logic     clk,
	input  tbl_req_t req,
	output entry_t   rdata
);

	entry_t mem [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.en && req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.en && !req.we) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

FILE: rtl/first_fit_block_allocator.sv
// first_fit_block_allocator: sequencer over the block table; the start and merge sums share one adder
// depends on ffba_pkg and ffba_table
//
// channel  dir  fields (low bit up)
// s_*      in   tuser: kind[1:0]; tdata: req_size[20:0] free_offset[40:21]
// m_*      out  tdata: status[1:0] alloc_offset[21:2]
// cfg_*    in   cfg_index 0 pool_bytes, 1 split_threshold; cfg_data
//
// an item reads each table entry it scans, and reads then rewrites each entry moved
// by a split or merge, all through the one table port
// after reset the boot state builds entry zero before the first item is taken
// s_tready is high only while idle; a result waits in the output register
module first_fit_block_allocator import ffba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // req_size, free_offset
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // status, alloc_offset
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data
);

	state_t state_q, state_d, ret_q, ret_d;
	kind_t kind_q, kind_d;
	logic [SIZE_W-1:0] req_q, req_d, start_q, start_d, cur_q, cur_d, rem_q, rem_d;
	logic [OFS_W-1:0] tgt_q, tgt_d, ofs_q, ofs_d;
	logic [CNT_W-1:0] i_q, i_d, j_q, j_d, cnt_q, cnt_d;
	status_t stat_q, stat_d;
	logic [SIZE_W-1:0] pool_q, pool_clamp;
	logic [THR_W-1:0] thr_q;
	logic out_valid_q;
	logic [1:0] out_stat_q;
	logic [OFS_W-1:0] out_ofs_q;
	logic load_out;
	tbl_req_t tr;
	entry_t rd;
	logic [SIZE_W-1:0] alu_a, alu_sum, rem_c;
	logic [CNT_W-1:0] ip1, im1, jp1, jm1;

	ffba_table u_table (.clk(clk), .req(tr), .rdata(rd));

	assign pool_clamp = (pool_q > POOL_LIM) ? POOL_LIM : pool_q;
	assign alu_a      = (state_q == S_SC_CHK) ? start_q : cur_q;
	assign alu_sum    = alu_a + rd.size;
	assign rem_c      = rd.size - req_q;
	assign ip1        = i_q + CNT_W'(1);
	assign im1        = i_q - CNT_W'(1);
	assign jp1        = j_q + CNT_W'(1);
	assign jm1        = j_q - CNT_W'(1);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {2'b00, out_ofs_q, out_stat_q};

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		kind_d   = kind_q;
		req_d    = req_q;
		tgt_d    = tgt_q;
		start_d  = start_q;
		cur_d    = cur_q;
		rem_d    = rem_q;
		ofs_d    = ofs_q;
		i_d      = i_q;
		j_d      = j_q;
		cnt_d    = cnt_q;
		stat_d   = stat_q;
		load_out = 1'b0;
		tr       = '0;
		case (state_q)
			S_BOOT: begin
				tr      = '{en: 1'b1, we: 1'b1, addr: '0, wdata: '{size: pool_clamp, free: 1'b1}};
				cnt_d   = CNT_W'(1);
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					kind_d  = kind_t'(s_tuser);
					req_d   = s_tdata[20:0];
					tgt_d   = s_tdata[40:21];
					i_d     = '0;
					start_d = '0;
					ofs_d   = '0;
					stat_d  = ST_OK;
					case (kind_t'(s_tuser))
						KIND_ALLOC, KIND_FREE: state_d = S_SC_RD;
						KIND_INIT: begin
							tr = '{en: 1'b1, we: 1'b1, addr: '0,
								wdata: '{size: pool_clamp, free: 1'b1}};
							cnt_d   = CNT_W'(1);
							state_d = S_RESP;
						end
						default: state_d = S_RESP;
					endcase
				end
			end
			S_SC_RD: begin
				if (i_q < cnt_q) begin
					tr      = '{en: 1'b1, we: 1'b0, addr: i_q[IDX_W-1:0], wdata: '0};
					state_d = S_SC_CHK;
				end else begin
					stat_d  = (kind_q == KIND_ALLOC) ? ST_NOFIT : ST_BADOFS;
					state_d = S_RESP;
				end
			end
			S_SC_CHK: begin
				if (kind_q == KIND_ALLOC && rd.free && rd.size >= req_q) begin
					ofs_d = start_q[OFS_W-1:0];
					rem_d = rem_c;
					if (rem_c != '0 && rem_c >= SIZE_W'(thr_q) &&
					    cnt_q < CNT_W'(MAX_ENTRIES)) begin
						j_d     = cnt_q;
						state_d = S_SU_RD;
					end else begin
						tr = '{en: 1'b1, we: 1'b1, addr: i_q[IDX_W-1:0],
							wdata: '{size: rd.size, free: 1'b0}};
						state_d = S_RESP;
					end
				end else if (kind_q == KIND_FREE && start_q == {1'b0, tgt_q} && !rd.free) begin
					cur_d   = rd.size;
					state_d = S_R_RD;
				end else begin
					start_d = alu_sum;
					i_d     = ip1;
					state_d = S_SC_RD;
				end
			end
			S_SU_RD: begin
				if (j_q > ip1) begin
					tr      = '{en: 1'b1, we: 1'b0, addr: jm1[IDX_W-1:0], wdata: '0};
					state_d = S_SU_WR;
				end else begin
					state_d = S_SP_LO;
				end
			end
			S_SU_WR: begin
				tr      = '{en: 1'b1, we: 1'b1, addr: j_q[IDX_W-1:0], wdata: rd};
				j_d     = jm1;
				state_d = S_SU_RD;
			end
			S_SP_LO: begin
				tr = '{en: 1'b1, we: 1'b1, addr: i_q[IDX_W-1:0],
					wdata: '{size: req_q, free: 1'b0}};
				state_d = S_SP_HI;
			end
			S_SP_HI: begin
				tr = '{en: 1'b1, we: 1'b1, addr: ip1[IDX_W-1:0],
					wdata: '{size: rem_q, free: 1'b1}};
				cnt_d   = cnt_q + CNT_W'(1);
				state_d = S_RESP;
			end
			S_R_RD: begin
				if (ip1 < cnt_q) begin
					tr      = '{en: 1'b1, we: 1'b0, addr: ip1[IDX_W-1:0], wdata: '0};
					state_d = S_R_CHK;
				end else begin
					state_d = S_L_RD;
				end
			end
			S_R_CHK: begin
				if (rd.free) begin
					cur_d   = alu_sum;
					j_d     = ip1;
					ret_d   = S_L_RD;
					state_d = S_D_RD;
				end else begin
					state_d = S_L_RD;
				end
			end
			S_L_RD: begin
				if (i_q != '0) begin
					tr      = '{en: 1'b1, we: 1'b0, addr: im1[IDX_W-1:0], wdata: '0};
					state_d = S_L_CHK;
				end else begin
					tr = '{en: 1'b1, we: 1'b1, addr: i_q[IDX_W-1:0],
						wdata: '{size: cur_q, free: 1'b1}};
					state_d = S_RESP;
				end
			end
			S_L_CHK: begin
				if (rd.free) begin
					tr = '{en: 1'b1, we: 1'b1, addr: im1[IDX_W-1:0],
						wdata: '{size: alu_sum, free: 1'b1}};
					j_d     = i_q;
					ret_d   = S_RESP;
					state_d = S_D_RD;
				end else begin
					tr = '{en: 1'b1, we: 1'b1, addr: i_q[IDX_W-1:0],
						wdata: '{size: cur_q, free: 1'b1}};
					state_d = S_RESP;
				end
			end
			S_D_RD: begin
				if (jp1 < cnt_q) begin
					tr      = '{en: 1'b1, we: 1'b0, addr: jp1[IDX_W-1:0], wdata: '0};
					state_d = S_D_WR;
				end else begin
					cnt_d   = cnt_q - CNT_W'(1);
					state_d = ret_q;
				end
			end
			S_D_WR: begin
				tr      = '{en: 1'b1, we: 1'b1, addr: j_q[IDX_W-1:0], wdata: rd};
				j_d     = jp1;
				state_d = S_D_RD;
			end
			S_RESP: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_BOOT;
			ret_q       <= S_RESP;
			cnt_q       <= CNT_W'(1);
			pool_q      <= POOL_RESET;
			thr_q       <= THR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			cnt_q   <= cnt_d;
			if (cfg_valid && cfg_index == REG_POOL) begin
				pool_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == REG_THR) begin
				thr_q <= cfg_data[THR_W-1:0];
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q  <= kind_d;
		req_q   <= req_d;
		tgt_q   <= tgt_d;
		start_q <= start_d;
		cur_q   <= cur_d;
		rem_q   <= rem_d;
		ofs_q   <= ofs_d;
		i_q     <= i_d;
		j_q     <= j_d;
		stat_q  <= stat_d;
		if (load_out) begin
			out_stat_q <= stat_q;
			out_ofs_q  <= (stat_q == ST_OK) ? ofs_q : '0;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count out of range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser != KIND_NONE) |=> !s_tready)
		else $error("ready while an item is in work");

	a_ofs_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[21:2] != '0) |-> m_tdata[1:0] == ST_OK)
		else $error("offset given on a failed item");

endmodule
